/* rtl/core/rtf_pkg.sv */
// ----------------------------------------------------------------------------
// rtf_pkg - shared types and constants for the row three-tap filter
// Register indexes, fixed field widths, the tag that travels with each
// division through the divider chain, and the sequencer state type.
// ----------------------------------------------------------------------------
package rtf_pkg;

    // fixed widths of the configuration fields
    localparam int WEIGHT_W = 8;
    localparam int ROW_W    = 13;
    localparam int CFG_W    = 13;
    localparam int CFG_IDX_W = 2;

    // weight sum: three 8-bit signed values, magnitude at most 384
    localparam int DSUM_W = WEIGHT_W + 2;
    localparam int DMAG_W = WEIGHT_W + 1;

    // output buffer depth
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_LEFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_CENTER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_RIGHT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH     = 2'd3;

    // reset values
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_LEFT   = 8'sd1;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_CENTER = 8'sd2;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_RIGHT  = 8'sd1;
    localparam logic [ROW_W-1:0]    RST_ROW_WIDTH     = 13'd256;

    // control that rides along with one division
    typedef struct packed {
        logic valid;
        logic neg;      // quotient is negative
        logic row_end;
        logic last;
    } t_div_tag;

    // request sequencer
    typedef enum logic {
        ST_IDLE,
        ST_SECOND
    } t_state;

endpackage

/* rtl/core/rtf_div_cell.sv */
// ----------------------------------------------------------------------------
// rtf_div_cell - one restoring-division step
// Shifts in the next dividend bit, subtracts the divisor when it fits and
// shifts the quotient bit in. Registered; hands its result to the next cell.
// ----------------------------------------------------------------------------
module rtf_div_cell #(
    parameter int MAG_W = 25
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rtf_pkg::t_div_tag              i_tag,
    input  logic [rtf_pkg::DMAG_W-1:0]     i_dmag,
    input  logic [rtf_pkg::DMAG_W-1:0]     i_rem,
    input  logic [MAG_W-1:0]               i_nq,
    output rtf_pkg::t_div_tag              o_tag,
    output logic [rtf_pkg::DMAG_W-1:0]     o_rem,
    output logic [MAG_W-1:0]               o_nq
);

    rtf_pkg::t_div_tag                 r_tag;
    logic [rtf_pkg::DMAG_W-1:0]        r_rem;
    logic [MAG_W-1:0]                  r_nq;
    logic [rtf_pkg::DMAG_W:0]          trial;
    logic [rtf_pkg::DMAG_W:0]          diff;
    logic                              fits;

    // trial subtract
    assign trial = {i_rem, i_nq[MAG_W-1]};
    assign fits  = trial >= {1'b0, i_dmag};
    assign diff  = trial - {1'b0, i_dmag};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= i_tag;
        end
    end

    // data path, no reset
    always_ff @(posedge i_clk) begin
        r_rem <= fits ? diff[rtf_pkg::DMAG_W-1:0] : trial[rtf_pkg::DMAG_W-1:0];
        r_nq  <= {i_nq[MAG_W-2:0], fits};
    end

    assign o_tag = r_tag;
    assign o_rem = r_rem;
    assign o_nq  = r_nq;

endmodule

/* rtl/core/rtf_div_chain.sv */
// ----------------------------------------------------------------------------
// rtf_div_chain - row of division cells
// Unsigned magnitude divide, one quotient bit per cell, each cell registered.
// A new division may enter every cycle.
// ----------------------------------------------------------------------------
module rtf_div_chain #(
    parameter int MAG_W = 25
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rtf_pkg::t_div_tag              i_tag,
    input  logic [MAG_W-1:0]               i_mag,
    input  logic [rtf_pkg::DMAG_W-1:0]     i_dmag,
    output rtf_pkg::t_div_tag              o_tag,
    output logic [MAG_W-1:0]               o_quo
);

    rtf_pkg::t_div_tag             tag [MAG_W+1];
    logic [rtf_pkg::DMAG_W-1:0]    rem [MAG_W+1];
    logic [MAG_W-1:0]              nq  [MAG_W+1];

    // head of the chain: empty remainder, dividend in the shift field
    assign tag[0] = i_tag;
    assign rem[0] = '0;
    assign nq[0]  = i_mag;

    for (genvar k = 0; k < MAG_W; k++) begin : g_cell
        rtf_div_cell #(
            .MAG_W (MAG_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tag   (tag[k]),
            .i_dmag  (i_dmag),
            .i_rem   (rem[k]),
            .i_nq    (nq[k]),
            .o_tag   (tag[k+1]),
            .o_rem   (rem[k+1]),
            .o_nq    (nq[k+1])
        );
    end

    assign o_tag = tag[MAG_W];
    assign o_quo = nq[MAG_W];

endmodule

/* rtl/core/row_three_tap_normalized_filter.sv */
// ----------------------------------------------------------------------------
// row_three_tap_normalized_filter - horizontal three-tap normalized filter
// Pixels enter on i_valid/o_ready in raster order; results leave on
// o_valid/i_ready. Weights and row width come in through the write port
// (i_cfg_we, i_cfg_index, i_cfg_data) and may only change while idle.
// Each result is the weighted sum of a pixel and its two row neighbors
// (zero outside the row) divided by the weight sum (one if that is zero),
// truncated toward zero and saturated to PIXEL_BITS signed.
// The first pixel of a row gives no result; later ones release the result
// of the pixel before them; the last pixel of a row releases two.
// Stages: multiply on accept, sum stage, PIXEL_BITS+9 divider cells, output
// buffer. A request is taken while at most two results are outstanding,
// so with the receiver ready the divider chain length sets the rate.
// A row-ending pixel holds o_ready low while its second result issues.
// Reset (synchronous, active low) restores weights 1/2/1, width 256, starts
// a new row and empties the pipeline. A stalled receiver keeps results in a
// four-entry buffer and the input stops once that would overflow.
// ----------------------------------------------------------------------------
module row_three_tap_normalized_filter #(
    parameter int MAX_ROW_WIDTH = 4096,
    parameter int PIXEL_BITS    = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [rtf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rtf_pkg::CFG_W-1:0]         i_cfg_data,
    // pixel input
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [PIXEL_BITS-1:0]      i_pixel_in,
    // result output
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [PIXEL_BITS-1:0]      o_pixel_out,
    output logic                              o_row_end,
    output logic                              o_last_of_run
);

    localparam int COL_W  = $clog2(MAX_ROW_WIDTH);
    localparam int WIDE_W = (COL_W + 1 > rtf_pkg::ROW_W) ? COL_W + 1 : rtf_pkg::ROW_W;
    localparam int PROD_W = PIXEL_BITS + rtf_pkg::WEIGHT_W;
    localparam int NUM_W  = PIXEL_BITS + 10;
    localparam int MAG_W  = NUM_W - 1;

    localparam logic [WIDE_W-1:0] WMAX = WIDE_W'(MAX_ROW_WIDTH);
    localparam logic [WIDE_W-1:0] WMIN = WIDE_W'(2);
    localparam logic [MAG_W-1:0]  HI_MAG = MAG_W'((64'd1 << (PIXEL_BITS - 1)) - 64'd1);
    localparam logic [PIXEL_BITS-1:0] PIX_HI = PIXEL_BITS'((64'd1 << (PIXEL_BITS - 1)) - 64'd1);
    localparam logic [PIXEL_BITS-1:0] PIX_LO = PIXEL_BITS'(64'd1 << (PIXEL_BITS - 1));

    // configuration registers
    logic signed [rtf_pkg::WEIGHT_W-1:0] r_w_left, r_w_center, r_w_right;
    logic [rtf_pkg::ROW_W-1:0]           r_row_width;

    // row state
    logic [COL_W-1:0]                    r_col;
    logic signed [PIXEL_BITS-1:0]        r_prev, r_sprev;
    logic signed [PIXEL_BITS-1:0]        r_b_l, r_b_c;   // operands of the row's last result

    // sequencer
    rtf_pkg::t_state                     r_state, n_state;
    logic [rtf_pkg::FIFO_CW-1:0]         r_pending;

    // divisor
    logic signed [rtf_pkg::DSUM_W-1:0]   dsum, dsum_nz;
    logic [rtf_pkg::DMAG_W-1:0]          r_dmag;
    logic                                r_dneg;

    // multiply stage
    rtf_pkg::t_div_tag                   r_mul_tag;
    logic signed [PROD_W-1:0]            r_p_l, r_p_c, r_p_r;

    // sum stage
    rtf_pkg::t_div_tag                   r_sum_tag;
    logic [MAG_W-1:0]                    r_sum_mag;

    // job issue
    logic                                accept, ends, issue, issue_b;
    logic signed [PIXEL_BITS-1:0]        op_l, op_c, op_r;
    rtf_pkg::t_div_tag                   job_tag;
    logic [WIDE_W-1:0]                   w_ext, w_eff, col_ext;

    // output buffer
    logic [PIXEL_BITS-1:0]               r_fifo_pix  [rtf_pkg::FIFO_DEPTH];
    logic                                r_fifo_end  [rtf_pkg::FIFO_DEPTH];
    logic                                r_fifo_last [rtf_pkg::FIFO_DEPTH];
    logic [rtf_pkg::FIFO_AW-1:0]         r_wr_ptr, r_rd_ptr;
    logic [rtf_pkg::FIFO_CW-1:0]         r_count;
    logic                                pop;

    // divider ends
    rtf_pkg::t_div_tag                   div_tag;
    logic [MAG_W-1:0]                    div_quo;
    logic [PIXEL_BITS-1:0]               sat_pix;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_left    <= rtf_pkg::RST_WEIGHT_LEFT;
            r_w_center  <= rtf_pkg::RST_WEIGHT_CENTER;
            r_w_right   <= rtf_pkg::RST_WEIGHT_RIGHT;
            r_row_width <= rtf_pkg::RST_ROW_WIDTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rtf_pkg::CFG_WEIGHT_LEFT:   r_w_left    <= i_cfg_data[rtf_pkg::WEIGHT_W-1:0];
                rtf_pkg::CFG_WEIGHT_CENTER: r_w_center  <= i_cfg_data[rtf_pkg::WEIGHT_W-1:0];
                rtf_pkg::CFG_WEIGHT_RIGHT:  r_w_right   <= i_cfg_data[rtf_pkg::WEIGHT_W-1:0];
                rtf_pkg::CFG_ROW_WIDTH:     r_row_width <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // divisor: weight sum, zero taken as one, split into sign and magnitude
    assign dsum = rtf_pkg::DSUM_W'(r_w_left) + rtf_pkg::DSUM_W'(r_w_center)
                + rtf_pkg::DSUM_W'(r_w_right);
    assign dsum_nz = (dsum == '0) ? rtf_pkg::DSUM_W'(1) : dsum;

    always_ff @(posedge i_clk) begin
        r_dneg <= dsum_nz[rtf_pkg::DSUM_W-1];
        r_dmag <= dsum_nz[rtf_pkg::DSUM_W-1] ? rtf_pkg::DMAG_W'(-dsum_nz)
                                             : rtf_pkg::DMAG_W'(dsum_nz);
    end

    // ------------------------------------------------------------ row logic
    assign w_ext   = WIDE_W'(r_row_width);
    assign w_eff   = (w_ext < WMIN) ? WMIN : ((w_ext > WMAX) ? WMAX : w_ext);
    assign col_ext = WIDE_W'(r_col);
    assign ends    = col_ext >= (w_eff - WIDE_W'(1));

    assign o_ready = (r_state == rtf_pkg::ST_IDLE) && (r_pending <= rtf_pkg::FIFO_CW'(2));
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_prev  <= '0;
            r_sprev <= '0;
        end else if (accept) begin
            if (r_col == '0) begin
                r_sprev <= '0;
                r_prev  <= i_pixel_in;
                r_col   <= COL_W'(1);
            end else if (ends) begin
                r_col   <= '0;
                r_prev  <= '0;
                r_sprev <= '0;
            end else begin
                r_sprev <= r_prev;
                r_prev  <= i_pixel_in;
                r_col   <= r_col + COL_W'(1);
            end
        end
    end

    // operands of the row's final result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_l <= r_prev;
            r_b_c <= i_pixel_in;
        end
    end

    // ------------------------------------------------------------ sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rtf_pkg::ST_IDLE:   if (accept && (r_col != '0) && ends) n_state = rtf_pkg::ST_SECOND;
            rtf_pkg::ST_SECOND: n_state = rtf_pkg::ST_IDLE;
            default:            n_state = rtf_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        issue_b = 1'b0;
        issue   = 1'b0;
        unique case (r_state)
            rtf_pkg::ST_IDLE:   issue = accept && (r_col != '0);
            rtf_pkg::ST_SECOND: begin
                issue   = 1'b1;
                issue_b = 1'b1;
            end
            default: ;
        endcase
    end

    // operands and tag of the issued division
    always_comb begin
        if (issue_b) begin
            op_l = r_b_l;
            op_c = r_b_c;
            op_r = '0;
            job_tag = '{valid: 1'b1, neg: 1'b0, row_end: 1'b1, last: 1'b1};
        end else begin
            op_l = (r_col == COL_W'(1)) ? '0 : r_sprev;
            op_c = r_prev;
            op_r = i_pixel_in;
            job_tag = '{valid: issue, neg: 1'b0, row_end: 1'b0, last: !ends};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rtf_pkg::ST_IDLE;
            r_pending <= '0;
        end else begin
            r_state   <= n_state;
            r_pending <= r_pending + rtf_pkg::FIFO_CW'(issue) - rtf_pkg::FIFO_CW'(pop);
        end
    end

    // ------------------------------------------------------- multiply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_tag <= '0;
        end else begin
            r_mul_tag <= job_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_l <= PROD_W'(r_w_left)   * PROD_W'(op_l);
        r_p_c <= PROD_W'(r_w_center) * PROD_W'(op_c);
        r_p_r <= PROD_W'(r_w_right)  * PROD_W'(op_r);
    end

    // ------------------------------------------------------------ sum stage
    logic signed [NUM_W-1:0] num;
    assign num = NUM_W'(r_p_l) + NUM_W'(r_p_c) + NUM_W'(r_p_r);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_tag <= '0;
        end else begin
            r_sum_tag <= '{valid: r_mul_tag.valid, neg: num[NUM_W-1] ^ r_dneg,
                           row_end: r_mul_tag.row_end, last: r_mul_tag.last};
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum_mag <= num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
    end

    // -------------------------------------------------------------- divider
    rtf_div_chain #(
        .MAG_W (MAG_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_sum_tag),
        .i_mag   (r_sum_mag),
        .i_dmag  (r_dmag),
        .o_tag   (div_tag),
        .o_quo   (div_quo)
    );

    // sign and saturation
    always_comb begin
        if (!div_tag.neg) begin
            sat_pix = (div_quo > HI_MAG) ? PIX_HI : div_quo[PIXEL_BITS-1:0];
        end else if (div_quo > HI_MAG + MAG_W'(1)) begin
            sat_pix = PIX_LO;
        end else begin
            sat_pix = -div_quo[PIXEL_BITS-1:0];
        end
    end

    // -------------------------------------------------------- output buffer
    assign pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (div_tag.valid) r_wr_ptr <= r_wr_ptr + rtf_pkg::FIFO_AW'(1);
            if (pop)           r_rd_ptr <= r_rd_ptr + rtf_pkg::FIFO_AW'(1);
            r_count <= r_count + rtf_pkg::FIFO_CW'(div_tag.valid) - rtf_pkg::FIFO_CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_tag.valid) begin
            r_fifo_pix[r_wr_ptr]  <= sat_pix;
            r_fifo_end[r_wr_ptr]  <= div_tag.row_end;
            r_fifo_last[r_wr_ptr] <= div_tag.last;
        end
    end

    assign o_valid       = r_count != '0;
    assign o_pixel_out   = r_fifo_pix[r_rd_ptr];
    assign o_row_end     = r_fifo_end[r_rd_ptr];
    assign o_last_of_run = r_fifo_last[r_rd_ptr];

endmodule
